/* design/ele_pkg.sv */
// Package for the edge loop extractor.
// Holds the word types, command and status codes, and fixed field widths.
// No dependencies.
package ele_pkg;

  localparam int VW    = 5;  // vertex index width
  localparam int LOOPW = 3;  // loop number width
  localparam int CFGW  = 6;  // vertex count register width

  // Smallest vertex count and edge count that a decompose accepts, and
  // the length a walk must exceed to be kept as a loop.
  localparam int MIN_SIZE = 3;

  localparam logic [1:0] KIND_APPEND    = 2'd0;
  localparam logic [1:0] KIND_DECOMPOSE = 2'd1;
  localparam logic [1:0] KIND_CLEAR     = 2'd2;

  localparam logic [1:0] STATUS_LOOP  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_SHORT = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]    kind;
    logic [VW-1:0] vertex_a;
    logic [VW-1:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic [VW-1:0]    vertex_index;
    logic [LOOPW-1:0] loop_number;
    logic             loop_end;
    logic [1:0]       status;
    logic             last;
  } out_word_t;

  // Result of one edge table scan for a vertex.
  typedef struct packed {
    logic          done;
    logic [1:0]    count;
    logic [VW-1:0] nb0;
    logic [VW-1:0] nb1;
  } scan_res_t;

endpackage

/* design/ele_edge_scan.sv */
// Edge table memory and the shared compare unit that scans it.
// Depends on ele_pkg.
// One edge is read and matched against the scan vertex per cycle.
module ele_edge_scan #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  logic [$clog2(MAX_EDGES)-1:0]         wr_addr,
  input  logic [ele_pkg::VW-1:0]               wr_a,
  input  logic [ele_pkg::VW-1:0]               wr_b,
  input  logic [$clog2(MAX_EDGES+1)-1:0]       edges_stored,
  input  logic                                 scan_start,
  input  logic [((($clog2(MAX_VERTICES+1)) > ele_pkg::VW) ?
                 $clog2(MAX_VERTICES+1) : ele_pkg::VW)-1:0] scan_vertex,
  output ele_pkg::scan_res_t                   scan_res
);

  localparam int AW  = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (VCW > ele_pkg::VW) ? VCW : ele_pkg::VW;
  localparam int VW  = ele_pkg::VW;

  logic [2*VW-1:0] edge_mem [MAX_EDGES];
  logic [2*VW-1:0] rd_data_r;

  logic [EW-1:0] e_r;
  logic          pend_r;
  logic          busy_r;
  logic [1:0]    found_r;
  logic [VW-1:0] nb0_r;
  logic [VW-1:0] nb1_r;
  logic [CW-1:0] vtx_r;

  logic          issue;
  logic          full3;
  logic          finish;
  logic          hit_a;
  logic          hit_b;
  logic [VW-1:0] rd_a;
  logic [VW-1:0] rd_b;
  logic [VW-1:0] nb_sel;

  assign full3  = (found_r == 2'd3);
  assign issue  = busy_r && !full3 && (e_r < edges_stored);
  assign finish = busy_r && (full3 || (!pend_r && !(e_r < edges_stored)));

  assign rd_a   = rd_data_r[2*VW-1:VW];
  assign rd_b   = rd_data_r[VW-1:0];
  assign hit_a  = (CW'(rd_a) == vtx_r);
  assign hit_b  = (CW'(rd_b) == vtx_r);
  assign nb_sel = hit_a ? rd_b : rd_a;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      edge_mem[wr_addr] <= {wr_a, wr_b};
    end
    if (issue) begin
      rd_data_r <= edge_mem[e_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      found_r <= 2'd0;
      e_r     <= '0;
    end else if (scan_start) begin
      busy_r  <= 1'b1;
      pend_r  <= 1'b0;
      found_r <= 2'd0;
      e_r     <= '0;
    end else if (busy_r) begin
      pend_r <= issue;
      if (issue) begin
        e_r <= e_r + EW'(1);
      end
      if (pend_r && !full3 && (hit_a || hit_b)) begin
        found_r <= found_r + 2'd1;
      end
      if (finish) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      vtx_r <= scan_vertex;
    end
    if (busy_r && pend_r && !full3 && (hit_a || hit_b)) begin
      if (found_r == 2'd0) begin
        nb0_r <= nb_sel;
      end
      if (found_r == 2'd1) begin
        nb1_r <= nb_sel;
      end
    end
  end

  always_comb begin
    scan_res.done  = finish;
    scan_res.count = found_r;
    scan_res.nb0   = nb0_r;
    scan_res.nb1   = nb1_r;
  end

endmodule

/* design/ele_walker.sv */
// Decompose sequencer: vertex marks, walk control, loop buffer and emission.
// Depends on ele_pkg; drives the edge scan unit through its start port.
module ele_walker #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]    nv,
  input  logic [$clog2(MAX_EDGES+1)-1:0]       edges_stored,
  output logic                                 scan_start,
  output logic [((($clog2(MAX_VERTICES+1)) > ele_pkg::VW) ?
                 $clog2(MAX_VERTICES+1) : ele_pkg::VW)-1:0] scan_vertex,
  input  ele_pkg::scan_res_t                   scan_res,
  output logic                                 res_valid,
  output ele_pkg::out_word_t                   res_word,
  input  logic                                 res_take,
  output logic                                 busy
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int CW  = (VCW > ele_pkg::VW) ? VCW : ele_pkg::VW;
  localparam int VW  = ele_pkg::VW;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ERR      = 3'd1;
  localparam logic [2:0] ST_SEEK     = 3'd2;
  localparam logic [2:0] ST_STEP     = 3'd3;
  localparam logic [2:0] ST_SCAN     = 3'd4;
  localparam logic [2:0] ST_EMIT_RD  = 3'd5;
  localparam logic [2:0] ST_EMIT_OUT = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  logic [MAX_VERTICES-1:0]   marks_r;
  logic [VCW-1:0]            seek_r;
  logic [VIW-1:0]            cur_r;
  logic [VCW-1:0]            len_r;
  logic [VCW-1:0]            emit_r;
  logic [ele_pkg::LOOPW-1:0] loop_r;

  logic [VW-1:0] loop_mem [MAX_VERTICES];
  logic [VW-1:0] rdata_r;

  logic          too_few;
  logic          seek_in;
  logic          seek_marked;
  logic [CW-1:0] cur_ext;
  logic [CW-1:0] nb0_ext;
  logic [CW-1:0] nb1_ext;
  logic          two_nb;
  logic          go0;
  logic          go1;
  logic          is_end;

  assign too_few     = (nv < VCW'(ele_pkg::MIN_SIZE)) ||
                       (edges_stored < EW'(ele_pkg::MIN_SIZE));
  assign seek_in     = (seek_r < nv);
  assign seek_marked = marks_r[seek_r[VIW-1:0]];
  assign cur_ext     = CW'(cur_r);
  assign scan_vertex = cur_ext;
  assign nb0_ext     = CW'(scan_res.nb0);
  assign nb1_ext     = CW'(scan_res.nb1);
  assign two_nb      = (scan_res.count == 2'd2);
  // A neighbour at or above the vertex count counts as marked.
  assign go0 = two_nb && (nb0_ext < CW'(nv)) && !marks_r[nb0_ext[VIW-1:0]];
  assign go1 = two_nb && (nb1_ext < CW'(nv)) && !marks_r[nb1_ext[VIW-1:0]];
  assign is_end = ((emit_r + VCW'(1)) == len_r);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    scan_start = 1'b0;
    res_valid  = 1'b0;
    res_word   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = too_few ? ST_ERR : ST_SEEK;
        end
      end
      ST_ERR: begin
        res_valid       = 1'b1;
        res_word.status = ele_pkg::STATUS_SHORT;
        res_word.last   = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEEK: begin
        if (!seek_in) begin
          state_nxt = ST_DONE;
        end else if (!seek_marked) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        scan_start = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (go0 || go1) begin
            state_nxt = ST_STEP;
          end else if (len_r > VCW'(ele_pkg::MIN_SIZE)) begin
            state_nxt = ST_EMIT_RD;
          end else begin
            state_nxt = ST_SEEK;
          end
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        res_valid             = 1'b1;
        res_word.vertex_index = rdata_r;
        res_word.loop_number  = loop_r;
        res_word.loop_end     = is_end;
        res_word.status       = ele_pkg::STATUS_LOOP;
        res_word.last         = 1'b0;
        if (res_take) begin
          state_nxt = is_end ? ST_SEEK : ST_EMIT_RD;
        end
      end
      ST_DONE: begin
        res_valid       = 1'b1;
        res_word.status = ele_pkg::STATUS_DONE;
        res_word.last   = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      marks_r <= '0;
      loop_r  <= '0;
      seek_r  <= '0;
    end
    if (state_r == ST_SEEK && seek_in) begin
      if (seek_marked) begin
        seek_r <= seek_r + VCW'(1);
      end else begin
        cur_r <= seek_r[VIW-1:0];
        len_r <= '0;
      end
    end
    if (state_r == ST_STEP) begin
      marks_r[cur_r] <= 1'b1;
      len_r          <= len_r + VCW'(1);
    end
    if (state_r == ST_SCAN && scan_res.done) begin
      emit_r <= '0;
      if (go0) begin
        cur_r <= nb0_ext[VIW-1:0];
      end else if (go1) begin
        cur_r <= nb1_ext[VIW-1:0];
      end
    end
    if (state_r == ST_EMIT_OUT && res_take) begin
      if (is_end) begin
        loop_r <= loop_r + ele_pkg::LOOPW'(1);
      end else begin
        emit_r <= emit_r + VCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_STEP) begin
      loop_mem[len_r[VIW-1:0]] <= cur_ext[VW-1:0];
    end
    if (state_r == ST_EMIT_RD) begin
      rdata_r <= loop_mem[emit_r[VIW-1:0]];
    end
  end

endmodule

/* design/edge_loop_extractor.sv */
// Top level of the edge loop extractor.
// Depends on ele_pkg, ele_edge_scan and ele_walker.
//
// Edge loop extractor. Append and clear words give no result unless an
// append finds the edge table full, in which case the edge is dropped and
// one word with the table full status comes back. A decompose word starts a
// walk over the vertices below the configured vertex count (capped at
// MAX_VERTICES): each walk step marks a vertex and scans the edge table from
// the start for its first incident edges, one edge per cycle through the
// table's single read port. Kept loops come out one vertex word at a time,
// followed by one done word with last set; too few vertices or edges gives
// one error word instead. In_stall stays high for the whole decompose, and
// while a result word sits in the output register with out_stall high. The
// vertex count register must be written only while the block is idle; the
// block itself does not enforce it.
module edge_loop_extractor #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_EDGES    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ele_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ele_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [ele_pkg::CFGW-1:0]      cfg_data
);

  localparam int AW  = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int CW  = (VCW > ele_pkg::VW) ? VCW : ele_pkg::VW;

  logic [ele_pkg::CFGW-1:0] vcount_r;
  logic [EW-1:0]            es_r;
  logic                     out_valid_r;
  ele_pkg::out_word_t       out_word_r;

  logic               accept;
  logic               do_append;
  logic               table_full;
  logic               wr_en;
  logic               full_hit;
  logic               start;
  logic [VCW-1:0]     nv;
  logic               out_free;
  logic               res_take;
  logic               walk_busy;
  logic               scan_start;
  logic [CW-1:0]      scan_vertex;
  ele_pkg::scan_res_t scan_res;
  logic               res_valid;
  ele_pkg::out_word_t res_word;
  ele_pkg::out_word_t full_word;

  // The vertex count register can hold values above MAX_VERTICES; larger
  // values act as the maximum.
  assign nv = ({1'b0, vcount_r} > (ele_pkg::CFGW + 1)'(MAX_VERTICES)) ?
              VCW'(MAX_VERTICES) : vcount_r[VCW-1:0];

  // The input side waits during a decompose and while an unread result
  // blocks the output register.
  assign in_stall   = walk_busy || (out_valid_r && out_stall);
  assign accept     = in_valid && !in_stall;
  assign do_append  = accept && (in_data.kind == ele_pkg::KIND_APPEND);
  assign table_full = !(es_r < EW'(MAX_EDGES));
  assign wr_en      = do_append && !table_full;
  assign full_hit   = do_append && table_full;
  assign start      = accept && (in_data.kind == ele_pkg::KIND_DECOMPOSE);

  assign out_free = !out_valid_r || !out_stall;
  assign res_take = res_valid && out_free;

  always_comb begin
    full_word        = '0;
    full_word.status = ele_pkg::STATUS_FULL;
    full_word.last   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_we) begin
      vcount_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      es_r <= '0;
    end else if (accept && in_data.kind == ele_pkg::KIND_CLEAR) begin
      es_r <= '0;
    end else if (wr_en) begin
      es_r <= es_r + EW'(1);
    end
  end

  // Output register; a full-table word and a walker word never compete,
  // since appends are taken only while the walker is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (full_hit || res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (full_hit) begin
      out_word_r <= full_word;
    end else if (res_take) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  ele_edge_scan #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (wr_en),
    .wr_addr      (es_r[AW-1:0]),
    .wr_a         (in_data.vertex_a),
    .wr_b         (in_data.vertex_b),
    .edges_stored (es_r),
    .scan_start   (scan_start),
    .scan_vertex  (scan_vertex),
    .scan_res     (scan_res)
  );

  ele_walker #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .nv           (nv),
    .edges_stored (es_r),
    .scan_start   (scan_start),
    .scan_vertex  (scan_vertex),
    .scan_res     (scan_res),
    .res_valid    (res_valid),
    .res_word     (res_word),
    .res_take     (res_take),
    .busy         (walk_busy)
  );

endmodule
